[design/bgfl_pkg.sv]
`default_nettype none

package bgfl_pkg;

    // field widths
    localparam int MV_W   = 16;
    localparam int PCT_W  = 15;
    localparam int LVL_W  = 4;

    // product of a voltage difference and full scale, also the divider width
    localparam int PROD_W = 31;

    // constants of the gauge
    localparam logic [MV_W-1:0]  RESET_MV   = 16'd4200;
    localparam logic [PCT_W-1:0] FULL_Q8    = 15'd25600;
    localparam logic [LVL_W-1:0] LEVEL_NONE = 4'd11;
    localparam logic [LVL_W-1:0] LEVEL_TOP  = 4'd10;
    localparam logic [PCT_W-1:0] STEP_Q8    = 15'd2560;
    localparam logic [PCT_W-1:0] HYST_Q8    = 15'd512;

    // register map, index = byte address / 4
    localparam logic [2:0] REG_STBY_EMPTY = 3'd0;
    localparam logic [2:0] REG_STBY_FULL  = 3'd1;
    localparam logic [2:0] REG_FLY_EMPTY  = 3'd2;
    localparam logic [2:0] REG_FLY_FULL   = 3'd3;
    localparam logic [2:0] REG_DELAY      = 3'd4;

    // register reset values
    localparam logic [MV_W-1:0] RST_STBY_EMPTY = 16'd3000;
    localparam logic [MV_W-1:0] RST_STBY_FULL  = 16'd4200;
    localparam logic [MV_W-1:0] RST_FLY_EMPTY  = 16'd3000;
    localparam logic [MV_W-1:0] RST_FLY_FULL   = 16'd4000;
    localparam logic [MV_W-1:0] RST_DELAY      = 16'd5;

    // input item kinds
    localparam logic REQ_SAMPLE     = 1'b0;
    localparam logic REQ_DISCONNECT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_MUL,
        ST_DIV_PCT,
        ST_FINISH
    } bgfl_state_t;

endpackage

`default_nettype wire

[design/battery_gauge_filter_level.sv]
`default_nettype none

// Battery gauge: each voltage beat enters a TAPS-deep moving average (running
// sum and shift line), the average is turned into a Q7.8 charge percentage
// between the empty and full limits of the selected mode, clipped to 0..100,
// then into a level 0..10 with 2 points of hysteresis on the previous level,
// and a saturating disagreement counter toggles the normal/low state after
// change_delay disagreeing samples. A disconnect beat reports level 11.
// The average is a multiplication of the running sum by a reciprocal constant
// of TAPS. The percentage runs on a bit-serial restoring divider, one
// quotient bit per cycle. An item passes the accept, average, limit check
// and multiply, percentage division and finish states in that order.
// Samples whose percentage is zero by the limit checks skip the division,
// disconnect beats skip the limit checks as well. The finish state waits
// while the previous result is still stalled.
// The input stalls while an item is in work; the result sits in an output
// register, so the next item may be accepted while it waits.
module battery_gauge_filter_level
    import bgfl_pkg::*;
#(
    parameter int TAPS = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [MV_W-1:0]   sample_mv,
    input  wire logic              motors_off,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [MV_W-1:0]   filtered_mv,
    output logic      [PCT_W-1:0]  percent_q8,
    output logic      [LVL_W-1:0]  level,
    output logic                   state_changed,
    output logic                   battery_low
);

    localparam int SUM_W = MV_W + $clog2(TAPS);
    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(TAPS * 4200);

    // floor(sum / TAPS) = (sum * AVG_RECIP) >> AVG_SHIFT, exact over the sum range
    localparam int AVG_SHIFT = SUM_W + $clog2(TAPS);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int AVG_PW    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((longint'(1) << AVG_SHIFT) + longint'(TAPS) - 1) / longint'(TAPS));

    // configuration registers
    logic [MV_W-1:0] stby_empty_reg, stby_full_reg, fly_empty_reg, fly_full_reg;
    logic [MV_W-1:0] delay_reg;

    // filter state
    logic [MV_W-1:0]  hist_reg [TAPS];
    logic [MV_W-1:0]  hist_next [TAPS];
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [AVG_PW-1:0] avg_prod;

    // gauge state
    logic [LVL_W-1:0] prev_level_reg, prev_level_next;
    logic             low_reg, low_next;
    logic [MV_W-1:0]  dis_cnt_reg, dis_cnt_next;

    // sequencer and work registers
    bgfl_state_t      state_reg, state_next;
    logic             req_reg, req_next;
    logic [MV_W-1:0]  empty_reg, empty_next;
    logic [MV_W-1:0]  full_reg, full_next;
    logic [MV_W-1:0]  filt_reg, filt_next;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // bit-serial divider
    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [MV_W-1:0]   rem_reg, rem_next;
    logic [MV_W-1:0]   dvs_reg, dvs_next;
    logic [MV_W:0]     rem_try;
    logic              rem_ge;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [MV_W-1:0]   o_filt_reg, o_filt_next;
    logic [PCT_W-1:0]  o_pct_reg, o_pct_next;
    logic [LVL_W-1:0]  o_lvl_reg, o_lvl_next;
    logic              o_chg_reg, o_chg_next;
    logic              o_low_reg, o_low_next;

    // finish-stage helpers
    logic [LVL_W-1:0]  lvl_calc;
    logic              lvl_found;
    logic [PCT_W-1:0]  thr;
    logic [MV_W-1:0]   cnt_upd;

    logic              in_accept;
    logic              cfg_write;
    logic [2:0]        cfg_idx;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // register read
    always_comb
    begin
        case (cfg_idx)
            REG_STBY_EMPTY: prdata = {16'd0, stby_empty_reg};
            REG_STBY_FULL:  prdata = {16'd0, stby_full_reg};
            REG_FLY_EMPTY:  prdata = {16'd0, fly_empty_reg};
            REG_FLY_FULL:   prdata = {16'd0, fly_full_reg};
            REG_DELAY:      prdata = {16'd0, delay_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stby_empty_reg <= RST_STBY_EMPTY;
            stby_full_reg  <= RST_STBY_FULL;
            fly_empty_reg  <= RST_FLY_EMPTY;
            fly_full_reg   <= RST_FLY_FULL;
            delay_reg      <= RST_DELAY;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_STBY_EMPTY: stby_empty_reg <= pwdata[MV_W-1:0];
                REG_STBY_FULL:  stby_full_reg  <= pwdata[MV_W-1:0];
                REG_FLY_EMPTY:  fly_empty_reg  <= pwdata[MV_W-1:0];
                REG_FLY_FULL:   fly_full_reg   <= pwdata[MV_W-1:0];
                REG_DELAY:      delay_reg      <= pwdata[MV_W-1:0];
                default:        ;
            endcase
        end
    end

    // average by reciprocal multiplication of the registered sum
    assign avg_prod = AVG_PW'(sum_reg) * AVG_PW'(AVG_RECIP);

    // one restoring divider step
    always_comb
    begin
        rem_try = {rem_reg, dvd_reg[PROD_W-1]};
        rem_ge  = (rem_try >= {1'b0, dvs_reg});
    end

    // level search over the ten thresholds, hysteresis on the previous level
    always_comb
    begin
        lvl_calc  = LEVEL_TOP;
        lvl_found = 1'b0;
        thr       = '0;
        for (int i = 0; i < 10; i++)
        begin
            thr = PCT_W'(i) * STEP_Q8;
            if (prev_level_reg == LVL_W'(i))
                thr = thr + HYST_Q8;
            if (!lvl_found && (pct_reg <= thr))
            begin
                lvl_calc  = LVL_W'(i);
                lvl_found = 1'b1;
            end
        end
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        hist_next       = hist_reg;
        sum_next        = sum_reg;
        prev_level_next = prev_level_reg;
        low_next        = low_reg;
        dis_cnt_next    = dis_cnt_reg;
        req_next        = req_reg;
        empty_next      = empty_reg;
        full_next       = full_reg;
        filt_next       = filt_reg;
        pct_next        = pct_reg;
        cnt_next        = cnt_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        out_valid_next  = out_valid_reg && out_stall;
        o_filt_next     = o_filt_reg;
        o_pct_next      = o_pct_reg;
        o_lvl_next      = o_lvl_reg;
        o_chg_next      = o_chg_reg;
        o_low_next      = o_low_reg;
        cnt_upd         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_next   = req_type;
                    empty_next = motors_off ? stby_empty_reg : fly_empty_reg;
                    full_next  = motors_off ? stby_full_reg : fly_full_reg;
                    if (req_type == REQ_SAMPLE)
                    begin
                        sum_next = SUM_W'({1'b0, sum_reg} + (SUM_W+1)'(sample_mv)
                                   - (SUM_W+1)'(hist_reg[TAPS-1]));
                        for (int i = TAPS-1; i > 0; i--)
                            hist_next[i] = hist_reg[i-1];
                        hist_next[0] = sample_mv;
                    end
                    state_next = ST_DIV_AVG;
                end
            end

            ST_DIV_AVG:
            begin
                // average of the updated sum
                filt_next = avg_prod[AVG_SHIFT +: MV_W];
                pct_next  = '0;
                if (req_reg == REQ_DISCONNECT)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end

            ST_MUL:
            begin
                // zero charge by the limit checks skips the division
                if ((full_reg <= empty_reg) || (filt_reg <= empty_reg))
                    state_next = ST_FINISH;
                else
                begin
                    dvd_next   = PROD_W'(filt_reg - empty_reg) * PROD_W'(FULL_Q8);
                    rem_next   = '0;
                    dvs_next   = full_reg - empty_reg;
                    cnt_next   = CNT_W'(PROD_W - 1);
                    state_next = ST_DIV_PCT;
                end
            end

            ST_DIV_PCT:
            begin
                dvd_next = {dvd_reg[PROD_W-2:0], rem_ge};
                rem_next = rem_ge ? MV_W'(rem_try - {1'b0, dvs_reg}) : rem_try[MV_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // clip to full scale
                    if (dvd_next > PROD_W'(FULL_Q8))
                        pct_next = FULL_Q8;
                    else
                        pct_next = dvd_next[PCT_W-1:0];
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    o_filt_next    = filt_reg;
                    state_next     = ST_IDLE;
                    if (req_reg == REQ_DISCONNECT)
                    begin
                        prev_level_next = LEVEL_NONE;
                        o_pct_next      = '0;
                        o_lvl_next      = LEVEL_NONE;
                        o_chg_next      = 1'b0;
                        o_low_next      = low_reg;
                    end
                    else
                    begin
                        prev_level_next = lvl_calc;
                        // disagreement counter, saturating
                        if ((lvl_calc == '0) != low_reg)
                            cnt_upd = (dis_cnt_reg == '1) ? dis_cnt_reg
                                                          : dis_cnt_reg + 1'b1;
                        else
                            cnt_upd = '0;
                        o_chg_next = 1'b0;
                        low_next   = low_reg;
                        if (cnt_upd >= delay_reg)
                        begin
                            low_next   = !low_reg;
                            cnt_upd    = '0;
                            o_chg_next = 1'b1;
                        end
                        dis_cnt_next = cnt_upd;
                        o_pct_next   = pct_reg;
                        o_lvl_next   = lvl_calc;
                        o_low_next   = low_next;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < TAPS; i++)
                hist_reg[i] <= RESET_MV;
            sum_reg        <= SUM_RESET;
            prev_level_reg <= LEVEL_NONE;
            low_reg        <= 1'b0;
            dis_cnt_reg    <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hist_reg       <= hist_next;
            sum_reg        <= sum_next;
            prev_level_reg <= prev_level_next;
            low_reg        <= low_next;
            dis_cnt_reg    <= dis_cnt_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
        filt_reg   <= filt_next;
        pct_reg    <= pct_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        o_filt_reg <= o_filt_next;
        o_pct_reg  <= o_pct_next;
        o_lvl_reg  <= o_lvl_next;
        o_chg_reg  <= o_chg_next;
        o_low_reg  <= o_low_next;
    end

    assign out_valid     = out_valid_reg;
    assign filtered_mv   = o_filt_reg;
    assign percent_q8    = o_pct_reg;
    assign level         = o_lvl_reg;
    assign state_changed = o_chg_reg;
    assign battery_low   = o_low_reg;

endmodule

`default_nettype wire

[verif/tb_battery_gauge_filter_level.sv]
module tb_battery_gauge_filter_level
    import bgfl_pkg::*;
();

    localparam int TAPS         = 7;
    localparam int N_PHASE      = 8;
    localparam int PHASE_BEATS  = 185;
    localparam int MAX_WAIT     = 14;
    localparam int SETTLE       = 60;    // well above the latency of an item
    localparam int DRAIN_CYCLES = 80;
    localparam int STUCK_LIMIT  = 3000;
    localparam int MAX_PRINT    = 40;

    typedef struct packed {
        logic            kind;
        logic [MV_W-1:0] mv;
        logic            motors_off;
    } gauge_item_t;

    typedef struct packed {
        logic [MV_W-1:0]  filt;
        logic [PCT_W-1:0] pct;
        logic [LVL_W-1:0] lvl;
        logic             changed;
        logic             low;
    } gauge_result_t;

    // DUT ports
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [4:0]        paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              req_type   = REQ_SAMPLE;
    logic [MV_W-1:0]   sample_mv  = '0;
    logic              motors_off = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [MV_W-1:0]   filtered_mv;
    logic [PCT_W-1:0]  percent_q8;
    logic [LVL_W-1:0]  level;
    logic              state_changed;
    logic              battery_low;

    // gauge model state and register copy
    logic [MV_W-1:0]   hist_mv [TAPS];
    int                sum_mv;
    logic [LVL_W-1:0]  last_lvl;
    logic              low_st;
    logic [15:0]       miss_cnt;
    logic [MV_W-1:0]   cfg_mv [5];

    gauge_item_t       item_q [$];
    gauge_result_t     gauge_expect_q [$];

    // handshake bookkeeping
    int                in_beats   = 0;
    int                out_beats  = 0;
    int                drv_beats  = 0;
    int                mon_beats  = 0;
    int                drv_wait   = 0;
    int                out_wait   = 0;
    int                drv_draws  = 0;
    int                out_draws  = 0;
    int                stuck      = 0;
    logic              drv_next;
    gauge_item_t       drv_item;
    gauge_result_t     chk_want;

    int                n_err      = 0;
    int                n_disc     = 0;
    int                n_toggle   = 0;

    battery_gauge_filter_level #(.TAPS(TAPS)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .sample_mv     (sample_mv),
        .motors_off    (motors_off),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .filtered_mv   (filtered_mv),
        .percent_q8    (percent_q8),
        .level         (level),
        .state_changed (state_changed),
        .battery_low   (battery_low)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        n_err++;
        if (n_err <= MAX_PRINT)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // wait per beat; every fourth stretch of 40 draws runs with no idling
    function automatic int draw_wait(input int n);
        return (((n / 40) % 4) == 3) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void queue_item(input logic kind, input logic [MV_W-1:0] mv,
                                       input logic mo);
        item_q.push_back('{kind, mv, mo});
        if (kind == REQ_DISCONNECT)
            n_disc++;
    endfunction

    // Q7.8 charge between empty and full, truncated, clipped to 100 percent
    function automatic logic [PCT_W-1:0] charge_q8(input logic [MV_W-1:0] v,
                                                   input logic [MV_W-1:0] e,
                                                   input logic [MV_W-1:0] f);
        longint q;
        if (f <= e || v <= e)
            return '0;
        q = longint'(v - e) * longint'(FULL_Q8) / longint'(f - e);
        if (q > longint'(FULL_Q8))
            q = longint'(FULL_Q8);
        return q[PCT_W-1:0];
    endfunction

    // smallest level whose threshold covers pct; previous level gets hysteresis
    function automatic logic [LVL_W-1:0] level_of(input logic [PCT_W-1:0] pct);
        int thr;
        for (int i = 0; i < int'(LEVEL_TOP); i++)
        begin
            thr = i * int'(STEP_Q8) + ((last_lvl == i) ? int'(HYST_Q8) : 0);
            if (int'(pct) <= thr)
                return LVL_W'(i);
        end
        return LEVEL_TOP;
    endfunction

    // advance the gauge by one beat and return the result it must produce
    function automatic gauge_result_t gauge_predict(input gauge_item_t it);
        gauge_result_t   r;
        logic [MV_W-1:0] e;
        logic [MV_W-1:0] f;
        r = '0;
        if (it.kind == REQ_DISCONNECT)
        begin
            last_lvl = LEVEL_NONE;
            r.filt   = MV_W'(sum_mv / TAPS);
            r.lvl    = LEVEL_NONE;
            r.low    = low_st;
            return r;
        end
        sum_mv = sum_mv + int'(it.mv) - int'(hist_mv[TAPS-1]);
        for (int k = TAPS - 1; k > 0; k--)
            hist_mv[k] = hist_mv[k-1];
        hist_mv[0] = it.mv;
        r.filt = MV_W'(sum_mv / TAPS);
        e = it.motors_off ? cfg_mv[REG_STBY_EMPTY] : cfg_mv[REG_FLY_EMPTY];
        f = it.motors_off ? cfg_mv[REG_STBY_FULL]  : cfg_mv[REG_FLY_FULL];
        r.pct = charge_q8(r.filt, e, f);
        r.lvl = level_of(r.pct);
        last_lvl = r.lvl;
        // hysteresis counter: saturates, clears on agreement and on toggle
        if ((r.lvl == 0) != low_st)
        begin
            if (miss_cnt != 16'hFFFF)
                miss_cnt++;
        end
        else
            miss_cnt = '0;
        if (miss_cnt >= cfg_mv[REG_DELAY])
        begin
            low_st    = ~low_st;
            miss_cnt  = '0;
            r.changed = 1'b1;
        end
        r.low = low_st;
        return r;
    endfunction

    // APB write, then read back the same register
    task automatic set_reg(input logic [2:0] idx, input logic [MV_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cfg_mv[idx] = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[MV_W-1:0] !== val)
            flag_mismatch($sformatf("register %0d reads %0d, wrote %0d",
                                    idx, prdata[MV_W-1:0], val));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || in_valid || gauge_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // input driver: one beat in flight, random gap before each
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            drv_next = in_valid;
            if (in_valid && in_beats != drv_beats)
            begin
                drv_beats = in_beats;
                drv_next  = 1'b0;
            end
            if (!drv_next && item_q.size() > 0)
            begin
                if (drv_wait > 0)
                    drv_wait--;
                else
                begin
                    drv_item   = item_q.pop_front();
                    req_type   <= drv_item.kind;
                    sample_mv  <= drv_item.mv;
                    motors_off <= drv_item.motors_off;
                    drv_next   = 1'b1;
                    drv_wait   = draw_wait(drv_draws);
                    drv_draws++;
                end
            end
            in_valid <= drv_next;
        end
    end

    // accepted input beat: predict its result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            gauge_expect_q.push_back(gauge_predict('{req_type, sample_mv, motors_off}));
            in_beats <= in_beats + 1;
        end
    end

    // output stall: random hold per result, counted while a result is offered
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_beats != mon_beats)
            begin
                mon_beats = out_beats;
                out_wait  = draw_wait(out_draws);
                out_draws++;
            end
            if (out_wait > 0 && out_valid)
                out_wait--;
            out_stall <= (out_wait > 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            out_beats <= out_beats + 1;
            if (gauge_expect_q.size() == 0)
                flag_mismatch($sformatf("result beat %0d with nothing pending", out_beats));
            else
            begin
                chk_want = gauge_expect_q.pop_front();
                if (chk_want.changed)
                    n_toggle++;
                if (filtered_mv !== chk_want.filt)
                    flag_mismatch($sformatf("beat %0d filtered_mv %0d, want %0d",
                                            out_beats, filtered_mv, chk_want.filt));
                if (percent_q8 !== chk_want.pct)
                    flag_mismatch($sformatf("beat %0d percent_q8 %0d, want %0d",
                                            out_beats, percent_q8, chk_want.pct));
                if (level !== chk_want.lvl)
                    flag_mismatch($sformatf("beat %0d level %0d, want %0d",
                                            out_beats, level, chk_want.lvl));
                if (state_changed !== chk_want.changed)
                    flag_mismatch($sformatf("beat %0d state_changed %b, want %b",
                                            out_beats, state_changed, chk_want.changed));
                if (battery_low !== chk_want.low)
                    flag_mismatch($sformatf("beat %0d battery_low %b, want %b",
                                            out_beats, battery_low, chk_want.low));
            end
        end
    end

    // watchdog: cycles in which no beat and no register access moves
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            stuck <= 0;
        else if (stuck >= STUCK_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
            $display("** battery_gauge_filter_level: FAILED **");
            $finish;
        end
        else
            stuck <= stuck + 1;
    end

    initial
    begin
        logic [MV_W-1:0] knob [5];
        int              lo_mv;
        int              hi_mv;
        int              target;
        int              run_len;
        int              pick;
        int              mv;
        int              n;
        logic            mo;

        // model state after reset
        for (int k = 0; k < TAPS; k++)
            hist_mv[k] = RESET_MV;
        sum_mv   = TAPS * int'(RESET_MV);
        last_lvl = LEVEL_NONE;
        low_st   = 1'b0;
        miss_cnt = '0;
        cfg_mv[REG_STBY_EMPTY] = RST_STBY_EMPTY;
        cfg_mv[REG_STBY_FULL]  = RST_STBY_FULL;
        cfg_mv[REG_FLY_EMPTY]  = RST_FLY_EMPTY;
        cfg_mv[REG_FLY_FULL]   = RST_FLY_FULL;
        cfg_mv[REG_DELAY]      = RST_DELAY;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats on reset limits: full and over-full in both modes,
        // disconnects, a long run at zero that flips to low, a run at empty
        queue_item(REQ_SAMPLE, 16'd4200, 1'b1);
        queue_item(REQ_SAMPLE, 16'd4200, 1'b0);
        queue_item(REQ_DISCONNECT, 16'hFFFF, 1'b1);
        queue_item(REQ_SAMPLE, 16'hFFFF, 1'b1);
        queue_item(REQ_SAMPLE, 16'hFFFF, 1'b0);
        for (int k = 0; k < 8; k++)
            queue_item(REQ_SAMPLE, 16'd0, k[0]);
        queue_item(REQ_DISCONNECT, 16'd0, 1'b0);
        for (int k = 0; k < 7; k++)
            queue_item(REQ_SAMPLE, 16'd3000, k[0]);
        queue_item(REQ_SAMPLE, 16'd3600, 1'b1);
        queue_item(REQ_SAMPLE, 16'd4000, 1'b0);
        queue_item(REQ_SAMPLE, 16'd4100, 1'b1);
        queue_item(REQ_DISCONNECT, 16'd1234, 1'b0);
        wait_idle();

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            case (ph)
                0: knob = '{16'd3000, 16'd4200, 16'd3000, 16'd4000, 16'd5};
                1: knob = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1};
                2: knob = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
                3: knob = '{16'd3300, 16'd3300, 16'd3500, 16'd3500, 16'd0};
                4: knob = '{16'd3200, 16'd4150, 16'd3100, 16'd3950, 16'd3};
                default:
                begin
                    knob[REG_STBY_EMPTY] = 16'($urandom_range(2500, 3800));
                    knob[REG_STBY_FULL]  = ($urandom_range(0, 5) == 0)
                        ? 16'($urandom) : knob[REG_STBY_EMPTY] + 16'($urandom_range(0, 1500));
                    knob[REG_FLY_EMPTY]  = 16'($urandom_range(2500, 3800));
                    knob[REG_FLY_FULL]   = ($urandom_range(0, 5) == 0)
                        ? 16'($urandom) : knob[REG_FLY_EMPTY] + 16'($urandom_range(0, 1500));
                    knob[REG_DELAY]      = 16'($urandom_range(0, 12));
                end
            endcase

            // block is drained; let the last item fully retire before writing
            repeat (SETTLE) @(posedge clk);
            set_reg(REG_STBY_EMPTY, knob[REG_STBY_EMPTY]);
            set_reg(REG_STBY_FULL,  knob[REG_STBY_FULL]);
            set_reg(REG_FLY_EMPTY,  knob[REG_FLY_EMPTY]);
            set_reg(REG_FLY_FULL,   knob[REG_FLY_FULL]);
            set_reg(REG_DELAY,      knob[REG_DELAY]);

            lo_mv = int'(knob[REG_STBY_EMPTY]);
            hi_mv = lo_mv;
            for (int k = 1; k < 4; k++)
            begin
                if (int'(knob[k]) < lo_mv) lo_mv = int'(knob[k]);
                if (int'(knob[k]) > hi_mv) hi_mv = int'(knob[k]);
            end

            // runs around a target voltage so the average settles and the
            // low/normal counter sees sustained agreement or disagreement
            n = 0;
            while (n < PHASE_BEATS)
            begin
                run_len = $urandom_range(3, 25);
                pick    = $urandom_range(0, 9);
                if (pick < 6)
                    target = $urandom_range((lo_mv > 300) ? lo_mv - 300 : 0,
                                            (hi_mv < 65235) ? hi_mv + 300 : 65535);
                else if (pick < 8)
                    target = $urandom_range(0, 65535);
                else
                    target = (pick == 8) ? 0 : 65535;
                mo = 1'($urandom);
                for (int k = 0; k < run_len; k++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        queue_item(REQ_DISCONNECT, 16'($urandom), 1'($urandom));
                    else
                    begin
                        if (pick == 1)
                            mo = ~mo;
                        mv = target + int'($urandom_range(0, 100)) - 50;
                        if (mv < 0)
                            mv = 0;
                        else if (mv > 65535)
                            mv = 65535;
                        queue_item(REQ_SAMPLE, 16'(mv), mo);
                    end
                    n++;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (gauge_expect_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", gauge_expect_q.size()));

        $display("Run: %0d beats checked (%0d disconnects), %0d limit settings incl. extremes",
                 out_beats, n_disc, N_PHASE);
        $display("Run: %0d low/normal toggles, %0d mismatches", n_toggle, n_err);
        if (n_err == 0)
            $display("** battery_gauge_filter_level: PASSED **");
        else
            $display("** battery_gauge_filter_level: FAILED **");
        $finish;
    end

endmodule
